// ----- sv/fcla_pkg.sv -----
// ----------------------------------------------------------------------------
// fcla_pkg : shared types and constants of the free-list chunk allocator
// Sizes of the pool, link codes, request opcodes and the link store request.
// ----------------------------------------------------------------------------
package fcla_pkg;

   // Pool geometry: an index is 8 bits, a link carries one extra bit for none
   localparam int PoolChunks = 256;
   localparam int PoolUsed   = (PoolChunks > 256) ? 256 : ((PoolChunks < 1) ? 1 : PoolChunks);
   localparam int IdxWidth   = 8;
   localparam int LinkWidth  = 9;
   localparam logic [LinkWidth-1:0] LinkNone = 9'd256;
   localparam logic [LinkWidth-1:0] PoolUsedCode = LinkWidth'(PoolUsed);

   // Chunk size register
   localparam int ChunkWidth  = 13;
   localparam int OffsetWidth = 20;
   localparam logic [ChunkWidth-1:0] ChunkReset = 13'd8;
   localparam logic [ChunkWidth-1:0] ChunkMin   = 13'd8;
   localparam logic [ChunkWidth-1:0] ChunkMax   = 13'd4096;

   // Register file
   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 32;
   localparam logic RegChunkBytes = 1'b0;

   // Request opcodes
   typedef enum logic {
      OpAlloc   = 1'b0,
      OpRelease = 1'b1
   } op_type;

   // Request from the list control to the link store
   typedef struct packed {
      logic                 wr_en;
      logic [IdxWidth-1:0]  wr_addr;
      logic [LinkWidth-1:0] wr_data;
      logic                 rd_en;
      logic [IdxWidth-1:0]  rd_addr;
   } link_req_type;

   // Link of an entry that has not been written since reset
   function automatic logic [LinkWidth-1:0] reset_link(input logic [IdxWidth-1:0] a);
      logic [LinkWidth:0] nx;
      nx = {2'b00, a} + 10'd1;
      if (nx < {1'b0, PoolUsedCode}) begin
         return nx[LinkWidth-1:0];
      end
      return LinkNone;
   endfunction

endpackage

// ----- sv/fcla_csr.sv -----
// ----------------------------------------------------------------------------
// fcla_csr : APB-style register port of the allocator
// Holds chunk_bytes and supplies the clamped chunk size to the datapath.
// ----------------------------------------------------------------------------
module fcla_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [fcla_pkg::CsrAddrWidth-1:0]  paddr,
   input  logic [fcla_pkg::CsrDataWidth-1:0]  pwdata,
   output logic [fcla_pkg::CsrDataWidth-1:0]  prdata,
   output logic                               pready,
   output logic [fcla_pkg::ChunkWidth-1:0]    chunk_eff
);
   import fcla_pkg::*;

   logic [ChunkWidth-1:0] chunk_ff;
   logic [ChunkWidth-1:0] chunk_in;
   logic                  wr_hit;

   assign pready = 1'b1;

   // Write at the access cycle of a transaction to register 0
   assign wr_hit   = psel && penable && pwrite && pready && (paddr[2] == RegChunkBytes);
   assign chunk_in = wr_hit ? pwdata[ChunkWidth-1:0] : chunk_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_ff <= ChunkReset;
      end else begin
         chunk_ff <= chunk_in;
      end
   end

   // Read back: register 0 only, zero elsewhere
   assign prdata = (paddr[2] == RegChunkBytes) ?
                   {{(CsrDataWidth-ChunkWidth){1'b0}}, chunk_ff} : '0;

   // Clamp to the supported chunk range
   always_comb begin
      if (chunk_ff < ChunkMin) begin
         chunk_eff = ChunkMin;
      end else if (chunk_ff > ChunkMax) begin
         chunk_eff = ChunkMax;
      end else begin
         chunk_eff = chunk_ff;
      end
   end

endmodule

// ----- sv/fcla_link_store.sv -----
// ----------------------------------------------------------------------------
// fcla_link_store : successor links of the free chunks
// One write and one registered read per cycle; valid bits give the
// power-up chain without a clearing pass.
// ----------------------------------------------------------------------------
module fcla_link_store (
   input  logic                             clock,
   input  logic                             reset,
   input  fcla_pkg::link_req_type           req,
   output logic [fcla_pkg::LinkWidth-1:0]   rd_data
);
   import fcla_pkg::*;

   localparam int Depth = 1 << IdxWidth;

   logic [LinkWidth-1:0] mem [Depth];
   logic [Depth-1:0]     valid_ff;
   logic [LinkWidth-1:0] rd_ff;

   // Link array write
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
   end

   // Written marks, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (req.wr_en) begin
         valid_ff[req.wr_addr] <= 1'b1;
      end
   end

   // Registered read; unwritten entries give the power-up chain
   always_ff @(posedge clock) begin
      if (req.rd_en) begin
         rd_ff <= valid_ff[req.rd_addr] ? mem[req.rd_addr] : reset_link(req.rd_addr);
      end
   end

   assign rd_data = rd_ff;

endmodule

// ----- sv/free_list_chunk_allocator.sv -----
// ----------------------------------------------------------------------------
// free_list_chunk_allocator : LIFO free list over a pool of equal chunks
// Pops a chunk on allocate, pushes it back on release.
// ----------------------------------------------------------------------------
// Usage
//   Request: drive req_op and req_chunk_index with start high; the request
//   is taken at any edge where start is high and busy is low. busy stays low,
//   so a request may be issued every cycle.
//   Result: rsp_strobe is high for one cycle, in the cycle after the request,
//   with rsp_granted, rsp_given_index and rsp_byte_offset. Results come in
//   request order and must be taken at once; the receiver cannot stall.
//   Throughput is one request per cycle. The head and the head's successor
//   are held in registers; the new head's successor after a pop comes from the
//   link store's registered read port in the cycle after the pop.
//   Configuration: chunk_bytes at byte address 0 over the APB-style port; the user
//   must write it only while no request is in flight, the block does not check.
//   Reset: head is chunk 0 and each chunk but the last links to the next; this is
//   immediate (valid bits on the link store, no clearing pass), and
//   chunk_bytes returns to 8.
// ----------------------------------------------------------------------------
module free_list_chunk_allocator (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_op,
   input  logic [fcla_pkg::IdxWidth-1:0]       req_chunk_index,
   // result channel
   output logic                                rsp_strobe,
   output logic                                rsp_granted,
   output logic [fcla_pkg::IdxWidth-1:0]       rsp_given_index,
   output logic [fcla_pkg::OffsetWidth-1:0]    rsp_byte_offset,
   // register port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [fcla_pkg::CsrAddrWidth-1:0]   paddr,
   input  logic [fcla_pkg::CsrDataWidth-1:0]   pwdata,
   output logic [fcla_pkg::CsrDataWidth-1:0]   prdata,
   output logic                                pready
);
   import fcla_pkg::*;

   logic [ChunkWidth-1:0]           chunk_eff;
   link_req_type                    link_req;
   logic [LinkWidth-1:0]            rd_data;

   logic [LinkWidth-1:0]            head_ff, head_in;
   logic [LinkWidth-1:0]            hnext_ff, hnext_in;
   logic                            sel_rd_ff, sel_rd_in;
   logic [LinkWidth-1:0]            hnext_eff;

   logic                            accept, do_alloc, do_rel;
   logic [IdxWidth+ChunkWidth-1:0]  product;

   logic                            strobe_ff, strobe_in;
   logic                            granted_ff, granted_in;
   logic [IdxWidth-1:0]             index_ff, index_in;
   logic [OffsetWidth-1:0]          offset_ff, offset_in;

   fcla_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .chunk_eff (chunk_eff)
   );

   fcla_link_store u_links (
      .clock   (clock),
      .reset   (reset),
      .req     (link_req),
      .rd_data (rd_data)
   );

   assign busy = 1'b0;

   // Request decode
   assign accept   = start && !busy;
   assign do_alloc = accept && (req_op == OpAlloc) && (head_ff < PoolUsedCode);
   assign do_rel   = accept && (req_op == OpRelease) &&
                     ({1'b0, req_chunk_index} < PoolUsedCode);

   // Successor of the head: fresh read after a pop, else held copy
   assign hnext_eff = sel_rd_ff ? rd_data : hnext_ff;

   // Head update
   always_comb begin
      head_in   = head_ff;
      hnext_in  = hnext_ff;
      sel_rd_in = sel_rd_ff;
      if (do_alloc) begin
         head_in   = hnext_eff;
         sel_rd_in = 1'b1;
      end else if (do_rel) begin
         head_in   = {1'b0, req_chunk_index};
         hnext_in  = head_ff;
         sel_rd_in = 1'b0;
      end
   end

   // Link store access: push writes the old head, pop prefetches the next link
   always_comb begin
      link_req.wr_en   = do_rel;
      link_req.wr_addr = req_chunk_index;
      link_req.wr_data = head_ff;
      link_req.rd_en   = do_alloc;
      link_req.rd_addr = hnext_eff[IdxWidth-1:0];
   end

   // Result values
   assign product    = head_ff[IdxWidth-1:0] * chunk_eff;
   assign strobe_in  = accept;
   assign granted_in = do_alloc || do_rel;
   assign index_in   = do_alloc ? head_ff[IdxWidth-1:0] : '0;
   assign offset_in  = do_alloc ? product[OffsetWidth-1:0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         hnext_ff   <= reset_link('0);
         sel_rd_ff  <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         head_ff    <= head_in;
         hnext_ff   <= hnext_in;
         sel_rd_ff  <= sel_rd_in;
         strobe_ff  <= strobe_in;
      end
   end

   // Result payload, no reset
   always_ff @(posedge clock) begin
      granted_ff <= granted_in;
      index_ff   <= index_in;
      offset_ff  <= offset_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_granted     = granted_ff;
   assign rsp_given_index = index_ff;
   assign rsp_byte_offset = offset_ff;

endmodule

// ----- verif/fcla_pool_checker.sv -----
// ----------------------------------------------------------------------------
// fcla_pool_checker : scoreboard for the free-list chunk allocator
// Mirrors the free list, the head and the chunk size register, works out the
// grant of every accepted request and compares it with the result transaction.
// ----------------------------------------------------------------------------
module fcla_pool_checker (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              start,
   input  logic                              busy,
   input  logic                              req_op,
   input  logic [fcla_pkg::IdxWidth-1:0]     req_chunk_index,
   // result channel
   input  logic                              rsp_strobe,
   input  logic                              rsp_granted,
   input  logic [fcla_pkg::IdxWidth-1:0]     rsp_given_index,
   input  logic [fcla_pkg::OffsetWidth-1:0]  rsp_byte_offset,
   // register port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic                              pready,
   input  logic [fcla_pkg::CsrAddrWidth-1:0] paddr,
   input  logic [fcla_pkg::CsrDataWidth-1:0] pwdata,
   // to the testbench top
   output int                                fail_count,
   output int                                pending
);
   import fcla_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CsrAddrWidth-1:0] ChunkBytesAddr = CsrAddrWidth'({RegChunkBytes, 2'b00});

   typedef struct packed {
      logic                   granted;
      logic [IdxWidth-1:0]    index;
      logic [OffsetWidth-1:0] offset;
   } grant_type;

   // Shadow of the pool
   logic [LinkWidth-1:0]  link_mem [PoolUsed];
   logic [LinkWidth-1:0]  free_head;
   logic [ChunkWidth-1:0] chunk_reg;
   grant_type             grant_queue [$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   // Pop the head on allocate, push the index on release
   function automatic grant_type serve_request(input op_type op,
                                               input logic [IdxWidth-1:0] idx);
      grant_type             g;
      logic [LinkWidth-1:0]  taken;
      logic [ChunkWidth-1:0] size;
      logic [31:0]           prod;
      g    = '0;
      size = chunk_reg;
      if (size < ChunkMin) size = ChunkMin;
      if (size > ChunkMax) size = ChunkMax;
      if (op == OpAlloc) begin
         if (free_head < PoolUsedCode) begin
            taken     = free_head;
            free_head = link_mem[taken[IdxWidth-1:0]];
            prod      = 32'(taken) * 32'(size);
            g.granted = 1'b1;
            g.index   = taken[IdxWidth-1:0];
            g.offset  = prod[OffsetWidth-1:0];
         end
      end else if ({1'b0, idx} < PoolUsedCode) begin
         link_mem[idx] = free_head;
         free_head     = {1'b0, idx};
         g.granted     = 1'b1;
      end
      return g;
   endfunction

   always @(posedge clock) begin
      grant_type want;
      if (reset) begin
         // every chunk links to the next one, the last to none
         for (int i = 0; i < PoolUsed; i++) begin
            link_mem[i] = (i + 1 < PoolUsed) ? LinkWidth'(i + 1) : LinkNone;
         end
         free_head = '0;
         chunk_reg = ChunkReset;
         grant_queue.delete();
      end else begin
         // result transaction against the oldest grant
         if (rsp_strobe) begin
            if (grant_queue.size() == 0) begin
               $error("result transaction with no request waiting");
               fail_count++;
            end else begin
               want = grant_queue.pop_front();
               if (rsp_granted !== want.granted) begin
                  $error("granted: expected %0d, got %0d", want.granted, rsp_granted);
                  fail_count++;
               end
               if (rsp_given_index !== want.index) begin
                  $error("given_index: expected %0d, got %0d", want.index, rsp_given_index);
                  fail_count++;
               end
               if (rsp_byte_offset !== want.offset) begin
                  $error("byte_offset: expected %0d, got %0d", want.offset, rsp_byte_offset);
                  fail_count++;
               end
            end
         end
         // register write; other addresses are ignored
         if (psel && penable && pwrite && pready && paddr == ChunkBytesAddr) begin
            chunk_reg = pwdata[ChunkWidth-1:0];
         end
         // accepted request transaction
         if (start && !busy) begin
            grant_queue.push_back(serve_request(op_type'(req_op), req_chunk_index));
         end
      end
      pending <= grant_queue.size();
   end

endmodule

// ----- verif/tb_free_list_chunk_allocator.sv -----
// ----------------------------------------------------------------------------
// tb_free_list_chunk_allocator : testbench of the free-list chunk allocator
// Directed allocate/release traffic over the chunk size extremes, then random
// phases that drain and refill the pool under several chunk sizes, with
// random gaps on the request side. Checking lives in fcla_pool_checker.
// ----------------------------------------------------------------------------
module tb_free_list_chunk_allocator;
   import fcla_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CsrAddrWidth-1:0] ChunkBytesAddr = CsrAddrWidth'({RegChunkBytes, 2'b00});
   localparam logic [CsrAddrWidth-1:0] UnusedAddr     = CsrAddrWidth'(4);

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic                    req_op = 1'b0;
   logic [IdxWidth-1:0]     req_chunk_index = '0;
   logic                    rsp_strobe;
   logic                    rsp_granted;
   logic [IdxWidth-1:0]     rsp_given_index;
   logic [OffsetWidth-1:0]  rsp_byte_offset;
   logic                    psel = 1'b0;
   logic                    penable = 1'b0;
   logic                    pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] paddr = '0;
   logic [CsrDataWidth-1:0] pwdata = '0;
   logic [CsrDataWidth-1:0] prdata;
   logic                    pready;
   int                      fail_count;
   int                      pending;

   int                      idle_pct = 10;
   op_type                  ops_in_flight [$];
   logic [IdxWidth-1:0]     held_chunks [$];

   always #4 clock = ~clock;

   free_list_chunk_allocator u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_chunk_index (req_chunk_index),
      .rsp_strobe      (rsp_strobe),
      .rsp_granted     (rsp_granted),
      .rsp_given_index (rsp_given_index),
      .rsp_byte_offset (rsp_byte_offset),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   fcla_pool_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_chunk_index (req_chunk_index),
      .rsp_strobe      (rsp_strobe),
      .rsp_granted     (rsp_granted),
      .rsp_given_index (rsp_given_index),
      .rsp_byte_offset (rsp_byte_offset),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .pready          (pready),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .fail_count      (fail_count),
      .pending         (pending)
   );

   // Keep the chunks handed out, so that most releases return a live chunk
   always @(posedge clock) begin
      op_type op;
      if (!reset) begin
         if (rsp_strobe && ops_in_flight.size() != 0) begin
            op = ops_in_flight.pop_front();
            if (op == OpAlloc && rsp_granted) held_chunks.push_back(rsp_given_index);
         end
         if (start && !busy) ops_in_flight.push_back(op_type'(req_op));
      end
   end

   // One request transaction, with random gaps ahead of it
   task automatic send(input op_type op, input logic [IdxWidth-1:0] idx);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start           <= 1'b1;
      req_op          <= op;
      req_chunk_index <= idx;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Register write once the block has gone quiet
   task automatic csr_write(input logic [CsrAddrWidth-1:0] addr,
                            input logic [ChunkWidth-1:0] value);
      logic [CsrDataWidth-1:0] noise;
      noise = $urandom();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= {noise[CsrDataWidth-1:ChunkWidth], value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Mostly allocates or returns live chunks; some releases hit free chunks
   task automatic random_phase(input int items, input int alloc_pct);
      int                  k;
      logic [IdxWidth-1:0] idx;
      for (int n = 0; n < items; n++) begin
         if ($urandom_range(99) < alloc_pct) begin
            send(OpAlloc, IdxWidth'($urandom_range(255)));
         end else if (held_chunks.size() != 0 && $urandom_range(9) != 0) begin
            k   = $urandom_range(held_chunks.size() - 1);
            idx = held_chunks[k];
            held_chunks.delete(k);
            send(OpRelease, idx);
         end else begin
            send(OpRelease, IdxWidth'($urandom_range(255)));
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: pops from a fresh list at the reset chunk size
      send(OpAlloc, 8'd255);
      send(OpAlloc, 8'd0);
      send(OpAlloc, 8'd170);
      send(OpRelease, 8'd1);
      send(OpAlloc, 8'd85);
      // release of a chunk that is still free
      send(OpRelease, 8'd255);
      send(OpAlloc, 8'd0);
      send(OpRelease, 8'd0);
      send(OpAlloc, 8'd0);

      // chunk size below the minimum
      csr_write(ChunkBytesAddr, 13'd0);
      send(OpAlloc, 8'd0);
      // largest chunk with the top index: largest offset
      csr_write(ChunkBytesAddr, 13'd4096);
      send(OpRelease, 8'd255);
      send(OpAlloc, 8'd0);
      // all ones, clamped to the maximum
      csr_write(ChunkBytesAddr, 13'h1FFF);
      send(OpRelease, 8'd254);
      send(OpAlloc, 8'd0);
      // just below the minimum
      csr_write(ChunkBytesAddr, 13'd7);
      send(OpRelease, 8'd200);
      send(OpAlloc, 8'd0);
      // just above the maximum; a write to an unused address is ignored
      csr_write(ChunkBytesAddr, 13'd4097);
      csr_write(UnusedAddr, 13'd8);
      send(OpAlloc, 8'd0);
      send(OpAlloc, 8'd0);

      // drain the pool well past empty
      csr_write(ChunkBytesAddr, 13'd4096);
      random_phase(350, 90);
      // refill with no gaps at all
      idle_pct = 0;
      csr_write(ChunkBytesAddr, 13'h1FFF);
      random_phase(200, 25);
      idle_pct = 10;
      csr_write(ChunkBytesAddr, 13'd7);
      random_phase(150, 50);
      csr_write(ChunkBytesAddr, ChunkWidth'($urandom_range(4095, 9)));
      random_phase(150, 60);
      csr_write(ChunkBytesAddr, 13'd4097);
      random_phase(100, 40);

      // drain the result side
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ----- files.f -----
sv/fcla_pkg.sv
sv/fcla_csr.sv
sv/fcla_link_store.sv
sv/free_list_chunk_allocator.sv
verif/fcla_pool_checker.sv
verif/tb_free_list_chunk_allocator.sv
